[hw/rtl/atilt_pkg.sv]
// Shared constants, types and a helper function for the accelerometer tilt-angle core.
package atilt_pkg;

   // Sample and pipeline sizing.
   localparam int SAMPLE_WIDTH  = 16;
   localparam int CORDIC_STAGES = 20;
   localparam int RAD_FRAC_BITS = 20;
   localparam int DEG_FRAC_BITS = 14;
   localparam int GUARD_BITS    = 30;

   // Fixed widths of the transaction fields.
   localparam int FIELD_WIDTH  = 16;
   localparam int MODE_WIDTH   = 2;
   localparam int UNIT_WIDTH   = 2;
   localparam int ANGLE_WIDTH  = 24;
   localparam int STATUS_WIDTH = 2;

   // Datapath widths. The CORDIC vector grows by at most 2.33x the sample magnitude.
   localparam int NEG_WIDTH = SAMPLE_WIDTH + 1;
   localparam int XY_WIDTH  = SAMPLE_WIDTH + GUARD_BITS + 3;
   localparam int Z_WIDTH   = 35;
   localparam int R_WIDTH   = 37;
   localparam int RC_WIDTH  = 35;

   // Angle constants in Q32 radians.
   localparam longint PI_Q60     = 64'sh3243F6A8885A308D;
   localparam longint PI_Q32     = (PI_Q60 + (longint'(1) <<< 27)) >>> 28;
   localparam longint TWO_PI_Q32 = 2 * PI_Q32;

   // Degree conversion: quotient estimate by reciprocal, then one exact correction.
   localparam longint DEG_SCALE     = 180 * (longint'(1) <<< DEG_FRAC_BITS);
   localparam int     DEG_SHIFT     = 40;
   localparam longint DEG_RECIP     = ((DEG_SCALE <<< DEG_SHIFT) + PI_Q32 / 2) / PI_Q32;
   localparam int     RECIP_WIDTH   = $clog2(DEG_RECIP + 1);
   localparam int     SCALE_WIDTH   = $clog2(DEG_SCALE + 1);
   localparam int     EST_WIDTH     = RC_WIDTH + RECIP_WIDTH + 1;
   localparam int     DEG_Q_WIDTH   = $clog2(360 * (longint'(1) <<< DEG_FRAC_BITS) + 2);
   localparam int     NUM_WIDTH     = RC_WIDTH + SCALE_WIDTH + 1;
   localparam int     REM_WIDTH     = NUM_WIDTH + 1;
   localparam int     RAD_SHIFT     = 32 - RAD_FRAC_BITS;

   // Axis select and unit select codes.
   localparam logic [MODE_WIDTH-1:0] MODE_X       = 2'd0;
   localparam logic [MODE_WIDTH-1:0] MODE_Y       = 2'd1;
   localparam logic [MODE_WIDTH-1:0] MODE_Z       = 2'd2;
   localparam logic [UNIT_WIDTH-1:0] UNIT_DEGREES = 2'd0;
   localparam logic [UNIT_WIDTH-1:0] UNIT_RADIANS = 2'd1;

   typedef enum logic [STATUS_WIDTH-1:0] {
      STATUS_OK          = 2'd0,
      STATUS_INVALID     = 2'd1,
      STATUS_READ_FAILED = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      SEL_ZERO = 2'd0,
      SEL_DEG  = 2'd1,
      SEL_RAD  = 2'd2
   } angle_sel_type;

   // Half-turn pre-rotation base plus pi: one of three fixed offsets.
   typedef enum logic [1:0] {
      OFFSET_ZERO   = 2'd0,
      OFFSET_PI     = 2'd1,
      OFFSET_TWO_PI = 2'd2
   } offset_type;

   // Control that travels alongside the CORDIC vector.
   typedef struct packed {
      logic          skip;
      offset_type    offset;
      angle_sel_type sel;
      status_type    status;
   } side_type;

   // Odd divisors of the arctangent series.
   localparam int     ATAN_TERMS = 30;
   localparam longint ODD_DIVISORS [ATAN_TERMS] = '{
      1, 3, 5, 7, 9, 11, 13, 15, 17, 19, 21, 23, 25, 27, 29,
      31, 33, 35, 37, 39, 41, 43, 45, 47, 49, 51, 53, 55, 57, 59
   };

   // atan(2^-idx) in Q32 radians: series in Q60 with truncated terms, rounded half up.
   function automatic longint atan_pow2_q32(input int unsigned idx);
      longint acc;
      longint term;
      int     shift;
      logic   neg;
      acc   = 0;
      term  = 0;
      shift = 0;
      neg   = 1'b0;
      if (idx == 0) begin
         acc = PI_Q60 / 4;
      end else begin
         for (int k = 0; k < ATAN_TERMS; k++) begin
            if (ODD_DIVISORS[k] * longint'(idx) <= 60) begin
               shift = int'(60 - ODD_DIVISORS[k] * longint'(idx));
               term  = (longint'(1) <<< shift) / ODD_DIVISORS[k];
               acc   = neg ? acc - term : acc + term;
               neg   = !neg;
            end
         end
      end
      return (acc + (longint'(1) <<< 27)) >>> 28;
   endfunction

endpackage

[hw/rtl/atilt_cordic.sv]
// Pipelined vectoring CORDIC: one micro-rotation per register stage, angle accumulated in Q32.
module atilt_cordic (
   input  logic                                      clock,
   input  logic                                      reset,
   input  logic                                      en,
   input  logic                                      in_valid,
   input  logic signed [atilt_pkg::XY_WIDTH-1:0]     in_x,
   input  logic signed [atilt_pkg::XY_WIDTH-1:0]     in_y,
   input  atilt_pkg::side_type                       in_side,
   output logic                                      out_valid,
   output logic signed [atilt_pkg::Z_WIDTH-1:0]      out_z,
   output atilt_pkg::side_type                       out_side
);

   localparam int N  = atilt_pkg::CORDIC_STAGES;
   localparam int XW = atilt_pkg::XY_WIDTH;
   localparam int ZW = atilt_pkg::Z_WIDTH;

   logic                 valid_ff [N];
   logic signed [XW-1:0] x_ff     [N];
   logic signed [XW-1:0] y_ff     [N];
   logic signed [ZW-1:0] z_ff     [N];
   atilt_pkg::side_type  side_ff  [N];

   for (genvar i = 0; i < N; i++) begin : g_stage
      localparam logic signed [ZW-1:0] ATAN_STEP = ZW'(atilt_pkg::atan_pow2_q32(i));

      logic                 src_valid;
      logic signed [XW-1:0] src_x;
      logic signed [XW-1:0] src_y;
      logic signed [ZW-1:0] src_z;
      atilt_pkg::side_type  src_side;
      logic signed [XW-1:0] x_in;
      logic signed [XW-1:0] y_in;
      logic signed [ZW-1:0] z_in;

      // The first stage starts from the pre-rotated vector with a zero angle.
      if (i == 0) begin : g_first
         assign src_valid = in_valid;
         assign src_x     = in_x;
         assign src_y     = in_y;
         assign src_z     = '0;
         assign src_side  = in_side;
      end else begin : g_next
         assign src_valid = valid_ff[i-1];
         assign src_x     = x_ff[i-1];
         assign src_y     = y_ff[i-1];
         assign src_z     = z_ff[i-1];
         assign src_side  = side_ff[i-1];
      end

      // Rotate toward the x axis by atan(2^-i), in the direction set by the sign of y.
      always_comb begin
         if (src_y >= 0) begin
            x_in = src_x + (src_y >>> i);
            y_in = src_y - (src_x >>> i);
            z_in = src_z + ATAN_STEP;
         end else begin
            x_in = src_x - (src_y >>> i);
            y_in = src_y + (src_x >>> i);
            z_in = src_z - ATAN_STEP;
         end
      end

      // Stage valid bit.
      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[i] <= 1'b0;
         end else if (en) begin
            valid_ff[i] <= src_valid;
         end
      end

      // Stage payload.
      always_ff @(posedge clock) begin
         if (en) begin
            x_ff[i]    <= x_in;
            y_ff[i]    <= y_in;
            z_ff[i]    <= z_in;
            side_ff[i] <= src_side;
         end
      end
   end

   assign out_valid = valid_ff[N-1];
   assign out_z     = z_ff[N-1];
   assign out_side  = side_ff[N-1];

endmodule

[hw/rtl/accel_tilt_angle_core.sv]
// Top level of the accelerometer tilt-angle core: operand select, CORDIC, unit scaling, output.
//
// The req channel carries one accelerometer sample per transaction; tuser selects the
// axis and the output unit and flags a failed sensor read. The rsp channel returns one
// transaction per request, in order: the tilt angle in tdata and a status code in tuser.
// The angle is atan2 of two negated components plus pi, in [0, 2pi], given in radians
// with 20 fraction bits or in degrees with 14 fraction bits.
// From the accepting edge to rsp_tvalid, the operand register loads on the accepting edge,
// then come one register per CORDIC micro-rotation, three scaling registers (clamp,
// multiply, multiply back) and the output register, which also takes the one-step
// quotient correction. Throughput is one transaction per cycle while the skid register
// is empty; the CORDIC is fully unrolled into stages.
// When the receiver stalls, the result moves into a one-entry skid register and the
// pipeline freezes only once that register is full, so req_tready is a registered signal.
// Reset clears all valid bits; no transaction is pending after reset and no clearing
// pass is needed.
module accel_tilt_angle_core (
   input  logic                                        clock,
   input  logic                                        reset,
   // Request: tdata = accel_x[15:0], accel_y[31:16], accel_z[47:32].
   input  logic                                        req_tvalid,
   output logic                                        req_tready,
   input  logic [3*atilt_pkg::FIELD_WIDTH-1:0]         req_tdata,
   // Request: tuser = mode[1:0], unit_select[3:2], read_fault[4].
   input  logic [4:0]                                  req_tuser,
   // Response: tdata = angle[23:0].
   output logic                                        rsp_tvalid,
   input  logic                                        rsp_tready,
   output logic [atilt_pkg::ANGLE_WIDTH-1:0]           rsp_tdata,
   // Response: tuser = status[1:0].
   output logic [atilt_pkg::STATUS_WIDTH-1:0]          rsp_tuser
);

   localparam int SW  = atilt_pkg::SAMPLE_WIDTH;
   localparam int FW  = atilt_pkg::FIELD_WIDTH;
   localparam int NW  = atilt_pkg::NEG_WIDTH;
   localparam int XW  = atilt_pkg::XY_WIDTH;
   localparam int ZW  = atilt_pkg::Z_WIDTH;
   localparam int RW  = atilt_pkg::R_WIDTH;
   localparam int CW  = atilt_pkg::RC_WIDTH;
   localparam int EW  = atilt_pkg::EST_WIDTH;
   localparam int QW  = atilt_pkg::DEG_Q_WIDTH;
   localparam int UW  = atilt_pkg::NUM_WIDTH;
   localparam int MW  = atilt_pkg::REM_WIDTH;
   localparam int AW  = atilt_pkg::ANGLE_WIDTH;
   localparam int SHW = atilt_pkg::RAD_SHIFT;

   localparam logic signed [RW-1:0] PI_R       = RW'(atilt_pkg::PI_Q32);
   localparam logic signed [RW-1:0] TWO_PI_R   = RW'(atilt_pkg::TWO_PI_Q32);
   localparam logic [CW-1:0]        TWO_PI_RC  = CW'(atilt_pkg::TWO_PI_Q32);
   localparam logic [EW-1:0]        RECIP_E    = EW'(atilt_pkg::DEG_RECIP);
   localparam logic [EW-1:0]        EST_HALF   = EW'(longint'(1) <<< (atilt_pkg::DEG_SHIFT - 1));
   localparam logic [UW-1:0]        SCALE_U    = UW'(atilt_pkg::DEG_SCALE);
   localparam logic [UW-1:0]        PI_HALF_U  = UW'(atilt_pkg::PI_Q32 / 2);
   localparam logic [UW-1:0]        PI_U       = UW'(atilt_pkg::PI_Q32);
   localparam logic signed [MW-1:0] PI_REM     = MW'(atilt_pkg::PI_Q32);
   localparam logic signed [MW-1:0] NEG_PI_REM = -MW'(atilt_pkg::PI_Q32);
   localparam logic signed [MW-1:0] TWO_PI_REM = MW'(atilt_pkg::TWO_PI_Q32);
   localparam logic [CW:0]          RAD_HALF   = (CW+1)'(1) << (SHW - 1);

   // Pipeline advance: frozen only while the skid register holds a result.
   logic en;
   logic skid_valid_ff;
   assign en         = !skid_valid_ff;
   assign req_tready = en;

   // Sample unpacking, sign extension to the sample width, and widened negation.
   logic signed [SW-1:0] sample_x;
   logic signed [SW-1:0] sample_y;
   logic signed [SW-1:0] sample_z;
   logic signed [NW-1:0] neg_x;
   logic signed [NW-1:0] neg_y;
   logic signed [NW-1:0] neg_z;
   logic [1:0]           req_mode;
   logic [1:0]           req_unit;
   logic                 req_fault;

   assign sample_x  = $signed(SW'(req_tdata[FW-1:0]));
   assign sample_y  = $signed(SW'(req_tdata[2*FW-1:FW]));
   assign sample_z  = $signed(SW'(req_tdata[3*FW-1:2*FW]));
   assign neg_x     = -(NW'(sample_x));
   assign neg_y     = -(NW'(sample_y));
   assign neg_z     = -(NW'(sample_z));
   assign req_mode  = req_tuser[1:0];
   assign req_unit  = req_tuser[3:2];
   assign req_fault = req_tuser[4];

   // Operand pair, half-turn pre-rotation and result control.
   logic signed [NW-1:0] op_a;
   logic signed [NW-1:0] op_b;
   logic                 mode_ok;
   logic signed [NW-1:0] rot_x;
   logic signed [NW-1:0] rot_y;
   logic signed [XW-1:0] p0_x_in;
   logic signed [XW-1:0] p0_y_in;
   atilt_pkg::side_type  p0_side_in;
   logic                 p0_valid_in;

   always_comb begin
      mode_ok = 1'b1;
      unique case (req_mode)
         atilt_pkg::MODE_X: begin
            op_a = neg_y;
            op_b = neg_z;
         end
         atilt_pkg::MODE_Y: begin
            op_a = neg_x;
            op_b = neg_z;
         end
         atilt_pkg::MODE_Z: begin
            op_a = neg_y;
            op_b = neg_x;
         end
         default: begin
            op_a    = '0;
            op_b    = '0;
            mode_ok = 1'b0;
         end
      endcase

      // A negative b turns the vector by a half turn into the right half plane.
      if (op_b < 0) begin
         rot_x             = -op_b;
         rot_y             = -op_a;
         p0_side_in.offset = (op_a >= 0) ? atilt_pkg::OFFSET_TWO_PI : atilt_pkg::OFFSET_ZERO;
      end else begin
         rot_x             = op_b;
         rot_y             = op_a;
         p0_side_in.offset = atilt_pkg::OFFSET_PI;
      end
      p0_side_in.skip = (op_a == 0);
      p0_x_in         = (XW'(rot_x)) <<< atilt_pkg::GUARD_BITS;
      p0_y_in         = (XW'(rot_y)) <<< atilt_pkg::GUARD_BITS;

      priority if (req_fault) begin
         p0_side_in.status = atilt_pkg::STATUS_READ_FAILED;
         p0_side_in.sel    = atilt_pkg::SEL_ZERO;
      end else if (!mode_ok) begin
         p0_side_in.status = atilt_pkg::STATUS_INVALID;
         p0_side_in.sel    = atilt_pkg::SEL_ZERO;
      end else if (req_unit == atilt_pkg::UNIT_DEGREES) begin
         p0_side_in.status = atilt_pkg::STATUS_OK;
         p0_side_in.sel    = atilt_pkg::SEL_DEG;
      end else if (req_unit == atilt_pkg::UNIT_RADIANS) begin
         p0_side_in.status = atilt_pkg::STATUS_OK;
         p0_side_in.sel    = atilt_pkg::SEL_RAD;
      end else begin
         p0_side_in.status = atilt_pkg::STATUS_INVALID;
         p0_side_in.sel    = atilt_pkg::SEL_ZERO;
      end
      p0_valid_in = req_tvalid;
   end

   // Operand register stage.
   logic                 p0_valid_ff;
   logic signed [XW-1:0] p0_x_ff;
   logic signed [XW-1:0] p0_y_ff;
   atilt_pkg::side_type  p0_side_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         p0_valid_ff <= 1'b0;
      end else if (en) begin
         p0_valid_ff <= p0_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         p0_x_ff    <= p0_x_in;
         p0_y_ff    <= p0_y_in;
         p0_side_ff <= p0_side_in;
      end
   end

   // CORDIC pipeline.
   logic                 cor_valid;
   logic signed [ZW-1:0] cor_z;
   atilt_pkg::side_type  cor_side;

   atilt_cordic u_cordic (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (p0_valid_ff),
      .in_x      (p0_x_ff),
      .in_y      (p0_y_ff),
      .in_side   (p0_side_ff),
      .out_valid (cor_valid),
      .out_z     (cor_z),
      .out_side  (cor_side)
   );

   // Stage 1: add the offset and clamp to [0, 2pi].
   logic signed [RW-1:0] off_val;
   logic signed [RW-1:0] r_sum;
   logic [CW-1:0]        f1_rc_in;

   always_comb begin
      unique case (cor_side.offset)
         atilt_pkg::OFFSET_PI:     off_val = PI_R;
         atilt_pkg::OFFSET_TWO_PI: off_val = TWO_PI_R;
         default:                  off_val = '0;
      endcase
      r_sum = off_val + (cor_side.skip ? RW'(0) : RW'(cor_z));
      priority if (r_sum < 0) begin
         f1_rc_in = '0;
      end else if (r_sum > TWO_PI_R) begin
         f1_rc_in = TWO_PI_RC;
      end else begin
         f1_rc_in = CW'(r_sum);
      end
   end

   logic                f1_valid_ff;
   logic [CW-1:0]       f1_rc_ff;
   atilt_pkg::side_type f1_side_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         f1_valid_ff <= 1'b0;
      end else if (en) begin
         f1_valid_ff <= cor_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         f1_rc_ff   <= f1_rc_in;
         f1_side_ff <= cor_side;
      end
   end

   // Stage 2: degree quotient estimate, exact degree numerator, rounded radians.
   logic [EW-1:0] f2_est_in;
   logic [UW-1:0] f2_num_in;
   logic [CW:0]   rad_sum;
   logic [AW-1:0] f2_rad_in;

   always_comb begin
      f2_est_in = EW'(f1_rc_ff) * RECIP_E + EST_HALF;
      f2_num_in = UW'(f1_rc_ff) * SCALE_U + PI_HALF_U;
      rad_sum   = (CW+1)'(f1_rc_ff) + RAD_HALF;
      f2_rad_in = AW'(rad_sum >> SHW);
   end

   logic                f2_valid_ff;
   logic [EW-1:0]       f2_est_ff;
   logic [UW-1:0]       f2_num_ff;
   logic [AW-1:0]       f2_rad_ff;
   atilt_pkg::side_type f2_side_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         f2_valid_ff <= 1'b0;
      end else if (en) begin
         f2_valid_ff <= f1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         f2_est_ff  <= f2_est_in;
         f2_num_ff  <= f2_num_in;
         f2_rad_ff  <= f2_rad_in;
         f2_side_ff <= f1_side_ff;
      end
   end

   // Stage 3: take the estimated quotient and multiply it back by pi.
   logic [QW-1:0] f3_u_in;
   logic [UW-1:0] f3_up_in;

   always_comb begin
      f3_u_in  = QW'(f2_est_ff >> atilt_pkg::DEG_SHIFT);
      f3_up_in = UW'(f3_u_in) * PI_U;
   end

   logic                f3_valid_ff;
   logic [QW-1:0]       f3_u_ff;
   logic [UW-1:0]       f3_up_ff;
   logic [UW-1:0]       f3_num_ff;
   logic [AW-1:0]       f3_rad_ff;
   atilt_pkg::side_type f3_side_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         f3_valid_ff <= 1'b0;
      end else if (en) begin
         f3_valid_ff <= f2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         f3_u_ff    <= f3_u_in;
         f3_up_ff   <= f3_up_in;
         f3_num_ff  <= f2_num_ff;
         f3_rad_ff  <= f2_rad_ff;
         f3_side_ff <= f2_side_ff;
      end
   end

   // Stage 4: correct the estimate by one either way and select the result angle.
   logic signed [MW-1:0] rem;
   logic [QW-1:0]        deg_q;
   logic [AW-1:0]        tail_angle;
   logic [1:0]           tail_status;

   always_comb begin
      rem = $signed({1'b0, f3_num_ff}) - $signed({1'b0, f3_up_ff});
      priority if (rem < 0) begin
         deg_q = f3_u_ff - QW'(1);
      end else if (rem >= PI_REM) begin
         deg_q = f3_u_ff + QW'(1);
      end else begin
         deg_q = f3_u_ff;
      end
      unique case (f3_side_ff.sel)
         atilt_pkg::SEL_DEG: tail_angle = AW'(deg_q);
         atilt_pkg::SEL_RAD: tail_angle = f3_rad_ff;
         default:            tail_angle = '0;
      endcase
      tail_status = f3_side_ff.status;
   end

   // Output register with a one-entry skid register behind it.
   logic          out_valid_ff;
   logic          out_valid_in;
   logic [AW-1:0] out_angle_ff;
   logic [AW-1:0] out_angle_in;
   logic [1:0]    out_status_ff;
   logic [1:0]    out_status_in;
   logic          out_load;
   logic          skid_valid_in;
   logic [AW-1:0] skid_angle_ff;
   logic [1:0]    skid_status_ff;
   logic          skid_load;

   always_comb begin
      out_load      = !out_valid_ff || rsp_tready;
      skid_load     = !out_load && en && f3_valid_ff;
      out_valid_in  = out_valid_ff;
      skid_valid_in = skid_valid_ff;
      if (out_load) begin
         out_valid_in  = skid_valid_ff || f3_valid_ff;
         skid_valid_in = 1'b0;
      end else if (skid_load) begin
         skid_valid_in = 1'b1;
      end
      out_angle_in  = skid_valid_ff ? skid_angle_ff : tail_angle;
      out_status_in = skid_valid_ff ? skid_status_ff : tail_status;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         out_angle_ff  <= out_angle_in;
         out_status_ff <= out_status_in;
      end
      if (skid_load) begin
         skid_angle_ff  <= tail_angle;
         skid_status_ff <= tail_status;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_angle_ff;
   assign rsp_tuser  = out_status_ff;

`ifndef SYNTHESIS
   // The skid register only fills behind a held output.
   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid register holds a result while the output register is empty");

   // The clamped angle never exceeds two pi.
   a_clamp_range: assert property (@(posedge clock) disable iff (reset)
      f1_valid_ff |-> (f1_rc_ff <= TWO_PI_RC))
      else $error("clamped angle above two pi");

   // The reciprocal estimate is off by at most one from the true degree quotient.
   a_deg_estimate: assert property (@(posedge clock) disable iff (reset)
      (f3_valid_ff && (f3_side_ff.sel == atilt_pkg::SEL_DEG))
         |-> ((rem >= NEG_PI_REM) && (rem < TWO_PI_REM)))
      else $error("degree quotient estimate off by more than one");

   // Every error status carries a zero angle.
   a_error_zero_angle: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && (rsp_tuser != 2'(atilt_pkg::STATUS_OK))) |-> (rsp_tdata == '0))
      else $error("nonzero angle reported with an error status");
`endif

endmodule

[tb/sv/tb.sv]
// Self-checking testbench for the accelerometer tilt-angle core on its request and response streams.
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   // Selector codes that the block must reject.
   localparam logic [atilt_pkg::MODE_WIDTH-1:0] MODE_NONE   = 2'd3;
   localparam logic [atilt_pkg::UNIT_WIDTH-1:0] UNIT_BAD_LO = 2'd2;
   localparam logic [atilt_pkg::UNIT_WIDTH-1:0] UNIT_BAD_HI = 2'd3;

   localparam int LATENCY         = atilt_pkg::CORDIC_STAGES + 5;
   localparam int HOLD_OFF_CYCLES = 200;
   localparam int PRESSURE_ITEMS  = 80;

   // Half turn in Q60 and Q32 radians.
   localparam longint HALF_TURN_Q60 = 64'sh3243F6A8885A308D;
   localparam longint HALF_TURN_Q32 = (HALF_TURN_Q60 + (longint'(1) <<< 27)) >>> 28;

   // Predicts the tilt angle of each accepted sample and checks results in order.
   class tilt_scoreboard;
      longint                            atan_step [atilt_pkg::CORDIC_STAGES];
      logic [atilt_pkg::ANGLE_WIDTH-1:0] expected_angle_q [$];
      atilt_pkg::status_type             expected_status_q [$];
      int unsigned                       mismatches;
      int unsigned                       checked;
      int unsigned                       n_invalid;
      int unsigned                       n_fault;

      function new();
         for (int i = 0; i < atilt_pkg::CORDIC_STAGES; i++) begin
            atan_step[i] = arctan_pow2(i);
         end
         mismatches = 0;
         checked    = 0;
         n_invalid  = 0;
         n_fault    = 0;
      endfunction

      // atan(2^-i) in Q32: alternating series in Q60 with truncated terms, rounded half up.
      function longint arctan_pow2(int i);
         longint          sum;
         longint unsigned part;
         bit              minus;
         sum   = 0;
         minus = 1'b0;
         if (i == 0) begin
            sum = HALF_TURN_Q60 / 4;
         end else begin
            for (int n = 1; n * i <= 60; n += 2) begin
               part  = (64'd1 << (60 - n * i)) / 64'(n);
               sum   = minus ? sum - longint'(part) : sum + longint'(part);
               minus = !minus;
            end
         end
         return (sum + (longint'(1) <<< 27)) >>> 28;
      endfunction

      // atan2(a, b) + pi in Q32 radians, clamped to [0, 2pi].
      function longint tilt_q32(longint a, longint b);
         longint x, y, z, base, r, xs, ys;
         z    = 0;
         base = 0;
         // Vectors in the left half plane are turned by a half turn first.
         if (b < 0) begin
            x    = -b * (longint'(1) <<< atilt_pkg::GUARD_BITS);
            y    = -a * (longint'(1) <<< atilt_pkg::GUARD_BITS);
            base = (a >= 0) ? HALF_TURN_Q32 : -HALF_TURN_Q32;
         end else begin
            x = b * (longint'(1) <<< atilt_pkg::GUARD_BITS);
            y = a * (longint'(1) <<< atilt_pkg::GUARD_BITS);
         end
         // A zero first component skips the micro-rotations entirely.
         if (y != 0) begin
            for (int i = 0; i < atilt_pkg::CORDIC_STAGES; i++) begin
               xs = x >>> i;
               ys = y >>> i;
               if (y >= 0) begin
                  x += ys;
                  y -= xs;
                  z += atan_step[i];
               end else begin
                  x -= ys;
                  y += xs;
                  z -= atan_step[i];
               end
            end
         end
         r = base + z + HALF_TURN_Q32;
         if (r < 0) r = 0;
         if (r > 2 * HALF_TURN_Q32) r = 2 * HALF_TURN_Q32;
         return r;
      endfunction

      // Works out the result of one accepted sample and queues it.
      function void note_sample(logic signed [atilt_pkg::FIELD_WIDTH-1:0] ax, ay, az,
                                logic [atilt_pkg::MODE_WIDTH-1:0] mode,
                                logic [atilt_pkg::UNIT_WIDTH-1:0] unit,
                                logic fault);
         longint                            r;
         logic [atilt_pkg::ANGLE_WIDTH-1:0] angle;
         atilt_pkg::status_type             status;
         r      = 0;
         angle  = '0;
         status = atilt_pkg::STATUS_OK;
         if (fault) begin
            status = atilt_pkg::STATUS_READ_FAILED;
         end else begin
            case (mode)
               atilt_pkg::MODE_X: r = tilt_q32(-longint'(ay), -longint'(az));
               atilt_pkg::MODE_Y: r = tilt_q32(-longint'(ax), -longint'(az));
               atilt_pkg::MODE_Z: r = tilt_q32(-longint'(ay), -longint'(ax));
               default:           status = atilt_pkg::STATUS_INVALID;
            endcase
            if (unit == atilt_pkg::UNIT_DEGREES) begin
               angle = atilt_pkg::ANGLE_WIDTH'(
                          (r * 180 * (longint'(1) <<< atilt_pkg::DEG_FRAC_BITS)
                           + HALF_TURN_Q32 / 2) / HALF_TURN_Q32);
            end else if (unit == atilt_pkg::UNIT_RADIANS) begin
               angle = atilt_pkg::ANGLE_WIDTH'(
                          (r + (longint'(1) <<< (31 - atilt_pkg::RAD_FRAC_BITS)))
                          >>> (32 - atilt_pkg::RAD_FRAC_BITS));
            end else begin
               status = atilt_pkg::STATUS_INVALID;
               angle  = '0;
            end
         end
         if (status == atilt_pkg::STATUS_INVALID) n_invalid++;
         if (status == atilt_pkg::STATUS_READ_FAILED) n_fault++;
         expected_angle_q.push_back(angle);
         expected_status_q.push_back(status);
      endfunction

      // Compares one response transaction with the oldest expectation.
      function void check_result(logic [atilt_pkg::ANGLE_WIDTH-1:0] angle,
                                 logic [atilt_pkg::STATUS_WIDTH-1:0] status);
         logic [atilt_pkg::ANGLE_WIDTH-1:0] exp_angle;
         atilt_pkg::status_type             exp_status;
         if (expected_angle_q.size() == 0) begin
            $error("unexpected result: angle %0d status %0d with nothing pending", angle, status);
            mismatches++;
            return;
         end
         exp_angle  = expected_angle_q.pop_front();
         exp_status = expected_status_q.pop_front();
         checked++;
         if (angle !== exp_angle) begin
            $error("angle mismatch: expected %0d, actual %0d", exp_angle, angle);
            mismatches++;
         end
         if (status !== exp_status) begin
            $error("status mismatch: expected %0d, actual %0d", exp_status, status);
            mismatches++;
         end
      endfunction

      function int pending();
         return expected_angle_q.size();
      endfunction
   endclass

   logic                                clock      = 1'b0;
   logic                                reset      = 1'b1;
   logic                                req_tvalid = 1'b0;
   logic                                req_tready;
   logic [3*atilt_pkg::FIELD_WIDTH-1:0] req_tdata  = '0;
   logic [4:0]                          req_tuser  = '0;
   logic                                rsp_tvalid;
   logic                                rsp_tready = 1'b0;
   logic [atilt_pkg::ANGLE_WIDTH-1:0]   rsp_tdata;
   logic [atilt_pkg::STATUS_WIDTH-1:0]  rsp_tuser;
   logic                                hold_off_asked = 1'b0;
   tilt_scoreboard                      board;

   accel_tilt_angle_core dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Record every accepted request transaction.
   always @(posedge clock) begin
      if (!reset && req_tvalid && req_tready) begin
         board.note_sample(req_tdata[15:0], req_tdata[31:16], req_tdata[47:32],
                           req_tuser[1:0], req_tuser[3:2], req_tuser[4]);
      end
   end

   // Check every accepted response transaction.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         board.check_result(rsp_tdata, rsp_tuser);
      end
   end

   // Receiver: stretches of differing stall density, plus one long hold-off on request.
   initial begin
      int stretch;
      int style;
      bit held;
      held = 1'b0;
      forever begin
         style   = $urandom_range(0, 3);
         stretch = $urandom_range(8, 60);
         repeat (stretch) begin
            @(posedge clock);
            if (hold_off_asked && !held) begin
               held = 1'b1;
               rsp_tready <= 1'b0;
               repeat (HOLD_OFF_CYCLES) @(posedge clock);
            end
            case (style)
               0:       rsp_tready <= 1'b1;
               1:       rsp_tready <= 1'($urandom_range(0, 1));
               2:       rsp_tready <= ($urandom_range(0, 7) == 0);
               default: rsp_tready <= ($urandom_range(0, 7) != 0);
            endcase
         end
      end
   end

   // Offer one sample and hold it until the block takes it.
   task automatic offer_sample(input logic signed [atilt_pkg::FIELD_WIDTH-1:0] ax, ay, az,
                               input logic [atilt_pkg::MODE_WIDTH-1:0] mode,
                               input logic [atilt_pkg::UNIT_WIDTH-1:0] unit,
                               input logic fault);
      req_tdata  <= {az, ay, ax};
      req_tuser  <= {fault, unit, mode};
      req_tvalid <= 1'b1;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   task automatic idle_sender(input int cycles);
      req_tvalid <= 1'b0;
      repeat (cycles) @(posedge clock);
   endtask

   // Random sample: mostly valid selectors, components biased toward extremes and zero.
   task automatic offer_random();
      logic signed [atilt_pkg::FIELD_WIDTH-1:0] v [3];
      logic [atilt_pkg::MODE_WIDTH-1:0]         mode;
      logic [atilt_pkg::UNIT_WIDTH-1:0]         unit;
      logic                                     fault;
      for (int k = 0; k < 3; k++) begin
         case ($urandom_range(0, 9))
            0:       v[k] = 16'sh8000;
            1:       v[k] = 16'sh7FFF;
            2:       v[k] = '0;
            3, 4:    v[k] = 16'($urandom_range(0, 64) - 32);
            default: v[k] = 16'($urandom());
         endcase
      end
      mode  = ($urandom_range(0, 15) == 0)
                 ? MODE_NONE
                 : 2'($urandom_range(atilt_pkg::MODE_X, atilt_pkg::MODE_Z));
      unit  = ($urandom_range(0, 7) == 0)
                 ? 2'($urandom_range(UNIT_BAD_LO, UNIT_BAD_HI))
                 : 2'($urandom_range(atilt_pkg::UNIT_DEGREES, atilt_pkg::UNIT_RADIANS));
      fault = ($urandom_range(0, 15) == 0);
      offer_sample(v[0], v[1], v[2], mode, unit, fault);
   endtask

   // Random samples in bursts of random length separated by random gaps.
   task automatic random_bursts(input int count);
      int burst;
      while (count > 0) begin
         burst = $urandom_range(1, 40);
         if (burst > count) burst = count;
         repeat (burst) offer_random();
         count -= burst;
         if ($urandom_range(0, 3) != 0) idle_sender($urandom_range(1, 12));
      end
   endtask

   task automatic wait_drained();
      while (board.pending() != 0) @(posedge clock);
   endtask

   // Main stimulus.
   initial begin
      board = new();
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Zero vectors on every axis and unit.
      offer_sample(0, 0, 0, atilt_pkg::MODE_X, atilt_pkg::UNIT_RADIANS, 1'b0);
      offer_sample(0, 0, 0, atilt_pkg::MODE_Y, atilt_pkg::UNIT_DEGREES, 1'b0);
      offer_sample(0, 0, 0, atilt_pkg::MODE_Z, atilt_pkg::UNIT_RADIANS, 1'b0);
      // Zero first component with the second of either sign.
      offer_sample(5, 0, 1000, atilt_pkg::MODE_X, atilt_pkg::UNIT_RADIANS, 1'b0);
      offer_sample(5, 0, -1000, atilt_pkg::MODE_X, atilt_pkg::UNIT_DEGREES, 1'b0);
      offer_sample(0, 77, 32767, atilt_pkg::MODE_Y, atilt_pkg::UNIT_RADIANS, 1'b0);
      // Most negative and most positive samples, where negation must widen.
      offer_sample(0, -32768, -32768, atilt_pkg::MODE_X, atilt_pkg::UNIT_RADIANS, 1'b0);
      offer_sample(32767, 0, -32768, atilt_pkg::MODE_Y, atilt_pkg::UNIT_DEGREES, 1'b0);
      offer_sample(32767, -32768, 0, atilt_pkg::MODE_Z, atilt_pkg::UNIT_RADIANS, 1'b0);
      offer_sample(-32768, 0, -32768, atilt_pkg::MODE_Y, atilt_pkg::UNIT_DEGREES, 1'b0);
      offer_sample(-32768, 32767, 0, atilt_pkg::MODE_Z, atilt_pkg::UNIT_RADIANS, 1'b0);
      // Angles close to both ends of the range, where clamping can act.
      offer_sample(32767, 1, 0, atilt_pkg::MODE_Z, atilt_pkg::UNIT_DEGREES, 1'b0);
      offer_sample(32767, -1, 0, atilt_pkg::MODE_Z, atilt_pkg::UNIT_RADIANS, 1'b0);
      offer_sample(-1, 0, 32767, atilt_pkg::MODE_Y, atilt_pkg::UNIT_RADIANS, 1'b0);
      offer_sample(0, 32767, 0, atilt_pkg::MODE_X, atilt_pkg::UNIT_DEGREES, 1'b0);
      offer_sample(0, -1, 1, atilt_pkg::MODE_X, atilt_pkg::UNIT_DEGREES, 1'b0);
      // Invalid axis and invalid unit.
      offer_sample(1234, -4321, 999, MODE_NONE, atilt_pkg::UNIT_RADIANS, 1'b0);
      offer_sample(-32768, 32767, -32768, MODE_NONE, atilt_pkg::UNIT_DEGREES, 1'b0);
      offer_sample(100, 200, 300, atilt_pkg::MODE_X, UNIT_BAD_LO, 1'b0);
      offer_sample(-100, -200, -300, atilt_pkg::MODE_Y, UNIT_BAD_HI, 1'b0);
      // Sensor read faults override everything else.
      offer_sample(100, 200, 300, atilt_pkg::MODE_X, atilt_pkg::UNIT_RADIANS, 1'b1);
      offer_sample(-32768, 32767, -1, MODE_NONE, UNIT_BAD_HI, 1'b1);
      offer_sample(32767, -32768, 32767, atilt_pkg::MODE_Z, atilt_pkg::UNIT_DEGREES, 1'b1);
      idle_sender(1);
      wait_drained();

      random_bursts(250);

      // Hold the result channel off while samples keep arriving back to back.
      hold_off_asked <= 1'b1;
      repeat (PRESSURE_ITEMS) offer_random();
      idle_sender(1);
      wait_drained();

      random_bursts(370);
      idle_sender(1);
      wait_drained();
      repeat (LATENCY + 10) @(posedge clock);

      $display("Checked %0d results on all axes and both units (%0d invalid, %0d read faults),",
               board.checked, board.n_invalid, board.n_fault);
      $display("with bursty input, random output stalls and one %0d-cycle output hold-off.",
               HOLD_OFF_CYCLES);
      if (board.mismatches == 0 && board.pending() == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

   // Run limit.
   initial begin
      #2_000_000;
      $display("Run limit reached with %0d results outstanding.", board.pending());
      $display("== FAIL ==");
      $finish;
   end

endmodule
